/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the tick budget generator RTL.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define FTBG_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define FTBG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define FTBG_ASSERT(lbl, clk, rst_n, prop, msg)

`define FTBG_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

/* hw/rtl/ftbg_pkg.sv */
// Package for the frame tick budget generator: word types, codes, widths,
// register reset values and the controller/datapath command structs.
// No dependencies.
package ftbg_pkg;

  localparam int unsigned FIELD_W   = 52;
  localparam int unsigned HZ_W      = 32;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned FRAC_W    = 21;
  localparam int unsigned PROD_W    = HZ_W + RATE_W;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [1:0] KIND_BEGIN   = 2'd0;
  localparam logic [1:0] KIND_CONSUME = 2'd1;
  localparam logic [1:0] KIND_RESET   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_CPU_HZ   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NTSC_NUM = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NTSC_DEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_NUM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PAL_DEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SLICE = 3'd5;

  localparam logic [HZ_W-1:0]    RST_CPU_HZ    = 32'd33868800;
  localparam logic [RATE_W-1:0]  RST_NTSC_NUM  = 20'd60000;
  localparam logic [RATE_W-1:0]  RST_NTSC_DEN  = 20'd1001;
  localparam logic [RATE_W-1:0]  RST_PAL_NUM   = 20'd50;
  localparam logic [RATE_W-1:0]  RST_PAL_DEN   = 20'd1;
  localparam logic [FIELD_W-1:0] RST_MAX_SLICE = 52'd4096;

  typedef struct packed {
    logic [1:0]         kind;
    logic               video_mode;
    logic [FIELD_W-1:0] consume_ticks;
  } ftbg_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] budget_ticks;
    logic [FIELD_W-1:0] slice_ticks;
    logic               accepted;
    logic               frame_done;
    logic               active_mode;
  } ftbg_out_t;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic frac;
    logic fin;
    logic commit;
    logic load_out;
  } ftbg_cmd_t;

  typedef struct packed {
    logic is_begin;
  } ftbg_sts_t;

endpackage

/* hw/rtl/ftbg_ctrl.sv */
// Controller for the frame tick budget generator: sequences one word at a
// time through setup, the bit-serial divide and remainder update (begin words only) and output.
// Depends on ftbg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ftbg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  input  ftbg_pkg::ftbg_sts_t sts_i,
  output ftbg_pkg::ftbg_cmd_t cmd_o
);
  import ftbg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PREP = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FRAC = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_PREP;
        end
      end
      S_PREP: begin
        cnt_d = '0;
        if (sts_i.is_begin) begin
          cmd_o.mul = 1'b1;
          state_d   = S_DIV;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = S_OUT;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_FRAC;
        end
      end
      S_FRAC: begin
        cmd_o.frac = 1'b1;
        state_d    = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FTBG_ASSERT(a_load_needs_slot, clk_i, rst_ni, cmd_o.load_out |-> slot_free, "output overwritten")
  `FTBG_ASSERT(a_accept_to_prep, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> (state_q == S_PREP), "accept did not start setup")
  `FTBG_ASSERT(a_div_ends, clk_i, rst_ni, (state_q == S_DIV && cnt_q == CNT_LAST) |=> (state_q == S_FRAC), "divide overran")
  `FTBG_ASSERT_NEVER(a_cnt_range, clk_i, rst_ni, (state_q == S_DIV) && (cnt_q > CNT_LAST), "divide count out of range")

endmodule

/* hw/rtl/ftbg_dp.sv */
// Datapath for the frame tick budget generator: configuration registers,
// product, restoring divider, remainder accumulator, budget and output word.
// Depends on ftbg_pkg.
module ftbg_dp #(
  parameter int unsigned TICK_WIDTH = 52
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ftbg_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ftbg_pkg::FIELD_W-1:0]      cfg_data_i,
  input  ftbg_pkg::ftbg_in_t                in_data_i,
  input  ftbg_pkg::ftbg_cmd_t               cmd_i,
  output ftbg_pkg::ftbg_sts_t               sts_o,
  output ftbg_pkg::ftbg_out_t               out_data_o
);
  import ftbg_pkg::*;

  localparam int unsigned CMP_W = (TICK_WIDTH > FIELD_W) ? TICK_WIDTH : FIELD_W;
  localparam logic [TICK_WIDTH-1:0] TICK_MAX = {TICK_WIDTH{1'b1}};

  logic [HZ_W-1:0]       cpu_hz_q;
  logic [RATE_W-1:0]     ntsc_num_q, ntsc_den_q, pal_num_q, pal_den_q;
  logic [FIELD_W-1:0]    max_slice_q;

  ftbg_in_t              item_q;
  logic                  mode_q;
  logic [FRAC_W-1:0]     frac_q;
  logic [TICK_WIDTH-1:0] budget_q;
  logic                  ok_q;
  logic [RATE_W-1:0]     num_q;
  logic [PROD_W-1:0]     quot_q;
  logic [RATE_W-1:0]     rem_q;
  logic [TICK_WIDTH-1:0] len_q;
  ftbg_out_t             out_q;

  logic [RATE_W-1:0]     num_sel, den_sel;
  logic [PROD_W-1:0]     prod;
  logic [RATE_W:0]       trial, num_x;
  logic                  trial_ge;
  logic [CMP_W-1:0]      budget_x, ticks_x, slice_x, quot_x;
  logic                  consume_ok;

  assign sts_o.is_begin = (item_q.kind == KIND_BEGIN);
  assign out_data_o     = out_q;

  assign num_sel = item_q.video_mode ? pal_num_q : ntsc_num_q;
  assign den_sel = item_q.video_mode ? pal_den_q : ntsc_den_q;
  assign prod    = cpu_hz_q * den_sel;

  assign num_x    = {1'b0, num_q};
  assign trial    = {rem_q, quot_q[PROD_W-1]};
  assign trial_ge = (trial >= num_x);

  assign budget_x   = CMP_W'(budget_q);
  assign ticks_x    = CMP_W'(item_q.consume_ticks);
  assign quot_x     = CMP_W'(quot_q);
  assign slice_x    = (budget_x < CMP_W'(max_slice_q)) ? budget_x : CMP_W'(max_slice_q);
  assign consume_ok = (item_q.consume_ticks != '0) && !(ticks_x > budget_x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_hz_q    <= RST_CPU_HZ;
      ntsc_num_q  <= RST_NTSC_NUM;
      ntsc_den_q  <= RST_NTSC_DEN;
      pal_num_q   <= RST_PAL_NUM;
      pal_den_q   <= RST_PAL_DEN;
      max_slice_q <= RST_MAX_SLICE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CPU_HZ:    cpu_hz_q    <= cfg_data_i[HZ_W-1:0];
        REG_NTSC_NUM:  ntsc_num_q  <= cfg_data_i[RATE_W-1:0];
        REG_NTSC_DEN:  ntsc_den_q  <= cfg_data_i[RATE_W-1:0];
        REG_PAL_NUM:   pal_num_q   <= cfg_data_i[RATE_W-1:0];
        REG_PAL_DEN:   pal_den_q   <= cfg_data_i[RATE_W-1:0];
        REG_MAX_SLICE: max_slice_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      frac_q   <= '0;
      budget_q <= '0;
    end else begin
      if (cmd_i.mul && (item_q.video_mode != mode_q)) begin
        mode_q <= item_q.video_mode;
        frac_q <= '0;
      end
      if (cmd_i.frac) begin
        frac_q <= frac_q + FRAC_W'(rem_q);
      end
      if (cmd_i.fin) begin
        if (frac_q >= FRAC_W'(num_q)) begin
          frac_q   <= frac_q - FRAC_W'(num_q);
          budget_q <= (len_q != TICK_MAX) ? len_q + 1'b1 : len_q;
        end else begin
          budget_q <= len_q;
        end
      end
      if (cmd_i.commit) begin
        case (item_q.kind)
          KIND_CONSUME: begin
            if (consume_ok) begin
              budget_q <= budget_q - TICK_WIDTH'(item_q.consume_ticks);
            end
          end
          KIND_RESET: begin
            frac_q   <= '0;
            budget_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      item_q <= in_data_i;
    end
    if (cmd_i.mul) begin
      ok_q   <= 1'b1;
      num_q  <= (num_sel == '0) ? RATE_W'(1) : num_sel;
      quot_q <= prod;
      rem_q  <= '0;
    end
    if (cmd_i.div_step) begin
      quot_q <= {quot_q[PROD_W-2:0], trial_ge};
      rem_q  <= trial_ge ? RATE_W'(trial - num_x) : trial[RATE_W-1:0];
    end
    if (cmd_i.frac) begin
      len_q <= (quot_x > CMP_W'(TICK_MAX)) ? TICK_MAX : TICK_WIDTH'(quot_q);
    end
    if (cmd_i.commit) begin
      case (item_q.kind)
        KIND_CONSUME: ok_q <= consume_ok;
        KIND_RESET:   ok_q <= 1'b1;
        default:      ok_q <= 1'b0;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.budget_ticks <= FIELD_W'(budget_q);
      out_q.slice_ticks  <= FIELD_W'(slice_x);
      out_q.accepted     <= ok_q;
      out_q.frame_done   <= (budget_q == '0);
      out_q.active_mode  <= mode_q;
    end
  end

endmodule

/* hw/rtl/frame_tick_budget_generator_unit.sv */
// Frame tick budget generator, top level: controller plus datapath.
// Depends on ftbg_pkg, ftbg_ctrl and ftbg_dp.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one word: begin
//   frame, consume ticks or reset. Each word gives exactly one result word
//   on the output channel (out_valid_o/out_ready_i/out_data_o).
//   Configuration channel (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i)
//   is always ready; write it only while the block is idle.
//   One word is processed at a time. A begin-frame word goes from the accept
//   state through a setup state with the 32x20 product, the one-bit-per-cycle
//   restoring divider, the remainder and budget update states and the load of
//   the output register. Consume and reset words skip the divide: setup
//   commits them and the output register is loaded. The next word is
//   accepted once the result is loaded.
//   The output register lets the next word be accepted while a result
//   still waits; if the receiver stalls, the following result holds in
//   the datapath and input stays blocked until the register frees.
//   Reset clears remainder, budget and mode (NTSC) and restores register defaults.
module frame_tick_budget_generator_unit #(
  parameter int unsigned TICK_WIDTH = 52
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  ftbg_pkg::ftbg_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output ftbg_pkg::ftbg_out_t            out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ftbg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ftbg_pkg::FIELD_W-1:0]   cfg_data_i
);
  import ftbg_pkg::*;

  ftbg_cmd_t cmd;
  ftbg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ftbg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ftbg_dp #(
    .TICK_WIDTH (TICK_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule
